// ===== rtl/core/q12atc_pkg.sv =====
// Package for the Q12 affine transform composer.
// Holds shared word, matrix and stage-control types and column codes.
// No dependencies.
package q12atc_pkg;

    localparam int NUM_ROWS  = 3;
    localparam int NUM_TERMS = 3;
    localparam int NUM_COLS  = 4;

    typedef logic signed [31:0] word_t;
    typedef logic signed [63:0] prod_t;
    typedef logic [1:0]         col_t;

    localparam col_t COL_FIRST = 2'd0;
    localparam col_t COL_TRANS = 2'd3;

    typedef word_t vec3_t [NUM_ROWS];
    typedef word_t mat3_t [NUM_ROWS][NUM_TERMS];
    typedef word_t hmat_t [NUM_ROWS][NUM_COLS];
    typedef prod_t pmat_t [NUM_ROWS][NUM_TERMS];

    typedef struct packed {
        logic valid;
        col_t col;
    } stage_ctl_t;

endpackage

// ===== rtl/core/q12atc_if.sv =====
// Valid/ready channel interfaces for the operand and result beats.
// Depends on q12atc_pkg.
interface q12atc_in_if import q12atc_pkg::*; ;
    logic  valid;
    logic  ready;
    logic  load;
    word_t col_row0;
    word_t col_row1;
    word_t col_row2;

    modport source (output valid, load, col_row0, col_row1, col_row2, input ready);
    modport sink   (input valid, load, col_row0, col_row1, col_row2, output ready);
endinterface

interface q12atc_out_if import q12atc_pkg::*; ;
    logic  valid;
    logic  ready;
    col_t  col_index;
    word_t res_row0;
    word_t res_row1;
    word_t res_row2;
    logic  last;

    modport source (output valid, col_index, res_row0, res_row1, res_row2, last,
                    input ready);
    modport sink   (input valid, col_index, res_row0, res_row1, res_row2, last,
                    output ready);
endinterface

// ===== rtl/core/q12_affine_transform_compose.sv =====
// Q12 affine transform composer. Holds a 3x4 affine transform H (column 3 is the
// translation) and right-multiplies it by an operand transform that arrives one
// column per operand beat, columns 0..3 in turn. Each beat yields one result
// beat carrying that product column; row i is the three 64-bit products summed
// (wrapping), shifted arithmetically right by FRACTION_BITS and wrapped to 32
// bits, plus H's translation on column 3. The beat of column 3 has last set, and
// at that point the product replaces H. Setting load on a column-0 beat makes
// H identity first, so the operand transform is simply loaded. Reset gives
// identity. Rate: one beat per cycle while the result side is not stalled.
// The input register loads at the accepting edge, then the product register
// of nine 32x32 multipliers, then the result register with the sum/shift/add
// in front of it. A stall on the result side backs up through the three
// registers; empty stages are filled on the fly.
// Depends on q12atc_pkg, q12atc_if, q12atc_colcnt, q12atc_mult, q12atc_reduce.
module q12_affine_transform_compose
    import q12atc_pkg::*;
#(
    parameter int FRACTION_BITS = 12
)
(
    input  logic          clk,
    input  logic          rst_n,
    q12atc_in_if.sink     operand,
    q12atc_out_if.source  result
);

    localparam word_t ONE = word_t'(1) <<< FRACTION_BITS;

    // ---- stage 0: input register ----
    logic  s0_valid_reg;
    logic  s0_valid_next;
    col_t  s0_col_reg;
    logic  s0_load_reg;
    vec3_t s0_b_reg;

    // ---- stage 1: product register control ----
    stage_ctl_t s1_ctl_reg;
    stage_ctl_t s1_ctl_next;
    pmat_t      s1_prod;

    // ---- output register ----
    logic  out_valid_reg;
    logic  out_valid_next;
    col_t  out_col_reg;
    vec3_t out_res_reg;
    logic  out_last_reg;

    // ---- held transform and partial product columns 0..2 ----
    hmat_t h_reg;
    hmat_t h_next;
    mat3_t pend_reg;

    col_t  cnt_col;
    logic  in_fire;
    logic  out_adv;
    logic  s1_adv;
    logic  s1_free;
    logic  s0_adv;
    logic  s0_free;
    logic  load_now;
    logic  s1_is_trans;
    mat3_t mul_src;
    vec3_t h_trans;
    vec3_t red_res;

    // Handshake flow: each stage moves when the one after it is empty or moving.
    assign out_adv       = !out_valid_reg || result.ready;
    assign s1_adv        = s1_ctl_reg.valid && out_adv;
    assign s1_free       = !s1_ctl_reg.valid || out_adv;
    assign s0_adv        = s0_valid_reg && s1_free;
    assign s0_free       = !s0_valid_reg || s1_free;
    assign operand.ready = s0_free;
    assign in_fire       = operand.valid && s0_free;

    assign load_now    = s0_load_reg && (s0_col_reg == COL_FIRST);
    assign s1_is_trans = s1_ctl_reg.valid && (s1_ctl_reg.col == COL_TRANS);

    q12atc_colcnt u_colcnt (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (in_fire),
        .col   (cnt_col)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= s0_valid_next;
    end

    always_comb
    begin
        s0_valid_next = in_fire ? 1'b1 : (s0_adv ? 1'b0 : s0_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s0_col_reg  <= cnt_col;
            s0_load_reg <= operand.load;
            s0_b_reg[0] <= operand.col_row0;
            s0_b_reg[1] <= operand.col_row1;
            s0_b_reg[2] <= operand.col_row2;
        end
    end

    // Multiplier source. A column-0 beat entering while the previous group's
    // column 3 leaves stage 1 must see the new H; its columns 0..2 are the
    // pending columns already. Load overrides with identity.
    always_comb
    begin
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            for (int k = 0; k < NUM_TERMS; k++)
            begin
                priority if (load_now)
                    mul_src[i][k] = (i == k) ? ONE : '0;
                else if (s1_is_trans)
                    mul_src[i][k] = pend_reg[i][k];
                else
                    mul_src[i][k] = h_reg[i][k];
            end
        end
    end

    q12atc_mult u_mult (
        .clk  (clk),
        .en   (s0_adv),
        .m    (mul_src),
        .b    (s0_b_reg),
        .prod (s1_prod)
    );

    always_comb
    begin
        s1_ctl_next = s1_ctl_reg;
        if (s0_adv)
        begin
            s1_ctl_next.valid = 1'b1;
            s1_ctl_next.col   = s0_col_reg;
        end
        else if (s1_adv)
        begin
            s1_ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_ctl_reg <= '{valid: 1'b0, col: COL_FIRST};
        else
            s1_ctl_reg <= s1_ctl_next;
    end

    always_comb
    begin
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            h_trans[i] = h_reg[i][NUM_COLS-1];
        end
    end

    q12atc_reduce #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_reduce (
        .prod      (s1_prod),
        .trans     (h_trans),
        .add_trans (s1_ctl_reg.col == COL_TRANS),
        .res       (red_res)
    );

    // Held transform: commit on column 3 leaving stage 1; a load entering
    // stage 1 in the same cycle comes after the commit and wins.
    always_comb
    begin
        h_next = h_reg;
        if (s1_adv && (s1_ctl_reg.col == COL_TRANS))
        begin
            for (int i = 0; i < NUM_ROWS; i++)
            begin
                for (int k = 0; k < NUM_TERMS; k++)
                begin
                    h_next[i][k] = pend_reg[i][k];
                end
                h_next[i][NUM_COLS-1] = red_res[i];
            end
        end
        if (s0_adv && load_now)
        begin
            for (int i = 0; i < NUM_ROWS; i++)
            begin
                for (int k = 0; k < NUM_COLS; k++)
                begin
                    h_next[i][k] = (i == k) ? ONE : '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ROWS; i++)
            begin
                for (int k = 0; k < NUM_COLS; k++)
                begin
                    h_reg[i][k] <= (i == k) ? ONE : '0;
                end
            end
        end
        else
        begin
            h_reg <= h_next;
        end
    end

    // Pending columns 0..2; column 3 goes straight into H.
    always_ff @(posedge clk)
    begin
        if (s1_adv && (s1_ctl_reg.col != COL_TRANS))
        begin
            for (int i = 0; i < NUM_ROWS; i++)
            begin
                pend_reg[i][s1_ctl_reg.col] <= red_res[i];
            end
        end
    end

    // ---- output register ----
    always_comb
    begin
        out_valid_next = out_adv ? s1_ctl_reg.valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_col_reg  <= s1_ctl_reg.col;
            out_res_reg  <= red_res;
            out_last_reg <= (s1_ctl_reg.col == COL_TRANS);
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.col_index = out_col_reg;
    assign result.res_row0  = out_res_reg[0];
    assign result.res_row1  = out_res_reg[1];
    assign result.res_row2  = out_res_reg[2];
    assign result.last      = out_last_reg;

    // ---- checks ----
    // Beats in flight are consecutive columns.
    a_col_s0_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (s0_valid_reg && s1_ctl_reg.valid) |->
            (s0_col_reg == col_t'(s1_ctl_reg.col + col_t'(1))))
        else $error("stage 0/1 column order broken");

    a_col_s1_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_ctl_reg.valid && out_valid_reg) |->
            (s1_ctl_reg.col == col_t'(out_col_reg + col_t'(1))))
        else $error("stage 1/output column order broken");

    a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == (out_col_reg == COL_TRANS)))
        else $error("last flag does not match translation column");

    a_load_ident: assert property (@(posedge clk) disable iff (!rst_n)
        (s0_adv && load_now) |=>
            (h_reg[0][0] == ONE && h_reg[0][NUM_COLS-1] == '0))
        else $error("load did not set identity");

endmodule

// ===== rtl/core/q12atc_mult.sv =====
// Product stage: nine 32x32 signed multipliers into a product register.
// Depends on q12atc_pkg.
module q12atc_mult
    import q12atc_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  mat3_t m,
    input  vec3_t b,
    output pmat_t prod
);

    pmat_t prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_ROWS; i++)
            begin
                for (int k = 0; k < NUM_TERMS; k++)
                begin
                    prod_reg[i][k] <= prod_t'(m[i][k]) * prod_t'(b[k]);
                end
            end
        end
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/q12atc_reduce.sv =====
// Reduce stage: three-term sum, arithmetic shift, wrap, translation add.
// Depends on q12atc_pkg.
module q12atc_reduce
    import q12atc_pkg::*;
#(
    parameter int FRACTION_BITS = 12
)
(
    input  pmat_t prod,
    input  vec3_t trans,
    input  logic  add_trans,
    output vec3_t res
);

    prod_t sum   [NUM_ROWS];
    prod_t shift [NUM_ROWS];

    always_comb
    begin
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            // 64-bit sum wraps
            sum[i]   = prod[i][0] + prod[i][1] + prod[i][2];
            shift[i] = sum[i] >>> FRACTION_BITS;
            res[i]   = add_trans ? word_t'(shift[i][31:0] + trans[i])
                                 : word_t'(shift[i][31:0]);
        end
    end

endmodule

// ===== rtl/core/q12atc_top_dummy_placeholder.sv =====
// Column sequence helper: counts operand beats modulo four.
// Depends on q12atc_pkg.
module q12atc_colcnt
    import q12atc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    output col_t col
);

    col_t cnt_reg;
    col_t cnt_next;

    always_comb
    begin
        cnt_next = step ? col_t'(cnt_reg + col_t'(1)) : cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= COL_FIRST;
        else
            cnt_reg <= cnt_next;
    end

    assign col = cnt_reg;

endmodule
